@@ hdl/bsr_pkg.sv @@
// Shared constants, state codes and slot index helpers for the byte stream reassembler.
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OFF_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_COUNT = 5'b00010,
        S_READ  = 5'b00100,
        S_OUT   = 5'b01000,
        S_NONE  = 5'b10000
    } state_t;

    // Advance a slot index by one, wrapping at the window size.
    function automatic idx_t idx_inc(input idx_t i);
        idx_t r;
        if (i == idx_t'(CAPACITY - 1))
            r = '0;
        else
            r = i + idx_t'(1);
        return r;
    endfunction

    // Add a window distance below CAPACITY to a slot index, wrapping once.
    function automatic idx_t idx_add(input idx_t a, input idx_t d);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, d};
        if (sum >= (IDX_W+1)'(CAPACITY))
            sum = sum - (IDX_W+1)'(CAPACITY);
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ hdl/byte_stream_reassembler.sv @@
// Byte stream reassembler: out-of-order byte slots in a circular memory, in-order drain.
//
// Input channel (s_*): one stream byte per transfer, tagged with its stream
// offset. s_tuser says whether the transfer carries a byte at all (clear for an
// end-only marker); s_tlast marks the end of the stream right after this item.
// Output channel (m_*): for every input transfer, either the run of in-order
// bytes it completes (one transfer per byte, m_tlast on the final one) or a
// single transfer with m_tuser clear when it completes nothing. Every result
// of an item carries the pending count and the finished flag after that item.
// Timing: the input is taken and the byte is written into its slot in the
// same cycle. An item that completes no run yields its result on the next
// cycle. An item that completes a run first walks the valid marks one slot
// per cycle, then emits each byte through S_READ (registered memory read)
// and S_OUT (byte shown on the output). The walk over the valid marks and
// the single read port of the slot memory set how long a run takes.
// s_tready is high only while no item is in flight; a stall on m_tready holds
// the current result and everything behind it, without losing bytes.
// Reset clears the valid marks, the window head, the counts and the end mark;
// the byte memory itself needs no clearing since only valid slots are read.
`timescale 1ns / 1ps

module byte_stream_reassembler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [bsr_pkg::IN_W-1:0]   s_tdata,   // [31:0] byte_offset, [39:32] byte_value
    input  logic                       s_tuser,   // carries_byte
    input  logic                       s_tlast,   // stream_end
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bsr_pkg::OUT_W-1:0]  m_tdata,   // [7:0] out_byte, [14:8] pending_count,
                                                  // [15] stream_finished
    output logic                       m_tuser,   // out_valid
    output logic                       m_tlast    // last_of_run
);

    import bsr_pkg::*;

    // Slot memory: one byte per window slot, addressed by circular slot index.
    logic [BYTE_W-1:0] slot_mem [CAPACITY];

    state_t              state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [OFF_W-1:0]    head_reg, head_next;       // next stream offset to emit
    idx_t                ptr_reg, ptr_next;         // slot that holds head_reg
    cnt_t                stored_reg, stored_next;
    logic                end_seen_reg, end_seen_next;
    logic [OFF_W-1:0]    end_off_reg, end_off_next;
    cnt_t                run_reg, run_next;         // run length, then bytes left
    idx_t                wptr_reg, wptr_next;       // walk pointer over valid marks
    logic [BYTE_W-1:0]   rd_data_reg;

    // Input fields
    logic [OFF_W-1:0]  in_off;
    logic [BYTE_W-1:0] in_byte;
    logic              in_has;
    logic              in_end;

    // Window test and store decision
    logic [OFF_W:0]    off_ext;
    logic [OFF_W:0]    head_ext;
    logic [OFF_W:0]    end_pos;
    logic [OFF_W-1:0]  head_gap;
    idx_t              store_idx;
    logic              in_window;
    logic              do_store;
    logic              mem_we;
    logic              s_xfer;
    logic              m_xfer;
    logic              finished;

    assign in_off  = s_tdata[OFF_W-1:0];
    assign in_byte = s_tdata[OFF_W +: BYTE_W];
    assign in_has  = s_tuser;
    assign in_end  = s_tlast;

    assign off_ext   = {1'b0, in_off};
    assign head_ext  = {1'b0, head_reg};
    assign end_pos   = off_ext + {{OFF_W{1'b0}}, in_has};
    assign head_gap  = in_off - head_reg;
    assign store_idx = idx_add(ptr_reg, head_gap[IDX_W-1:0]);

    // Drop items beyond the window or wholly behind the head.
    assign in_window = !(off_ext >= head_ext + (OFF_W+1)'(CAPACITY)) && !(end_pos < head_ext);
    assign do_store  = in_window && in_has && (in_off >= head_reg) && !valid_reg[store_idx];

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_NONE);
    assign m_xfer   = m_tvalid && m_tready;
    assign mem_we   = s_xfer && do_store;

    // The counts and the head are already final while results are shown.
    assign finished = end_seen_reg && (end_off_reg == head_reg);
    assign m_tuser  = (state_reg == S_OUT);
    assign m_tlast  = (state_reg == S_NONE) || (run_reg == cnt_t'(1));
    assign m_tdata  = {finished, PEND_W'(stored_reg),
                       (state_reg == S_OUT) ? rd_data_reg : {BYTE_W{1'b0}}};

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        head_next     = head_reg;
        ptr_next      = ptr_reg;
        stored_next   = stored_reg;
        end_seen_next = end_seen_reg;
        end_off_next  = end_off_reg;
        run_next      = run_reg;
        wptr_next     = wptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    if (in_window && in_end)
                    begin
                        end_seen_next = 1'b1;
                        end_off_next  = end_pos[OFF_W-1:0];
                    end
                    if (do_store)
                    begin
                        valid_next[store_idx] = 1'b1;
                        stored_next           = stored_reg + cnt_t'(1);
                    end
                    // The head slot is always empty between items, so a run
                    // starts only when this byte lands on it.
                    if (do_store && (head_gap == '0))
                    begin
                        run_next   = cnt_t'(1);
                        wptr_next  = idx_inc(ptr_reg);
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        state_next = S_NONE;
                    end
                end
            end
            S_COUNT:
            begin
                if ((run_reg < cnt_t'(CAPACITY)) && valid_reg[wptr_reg])
                begin
                    run_next  = run_reg + cnt_t'(1);
                    wptr_next = idx_inc(wptr_reg);
                end
                else
                begin
                    // Commit the slide of the window before the first result.
                    head_next   = head_reg + OFF_W'(run_reg);
                    stored_next = stored_reg - run_reg;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_xfer)
                begin
                    valid_next[ptr_reg] = 1'b0;
                    ptr_next            = idx_inc(ptr_reg);
                    run_next            = run_reg - cnt_t'(1);
                    state_next          = (run_reg == cnt_t'(1)) ? S_IDLE : S_READ;
                end
            end
            S_NONE:
            begin
                if (m_xfer)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            head_reg     <= '0;
            ptr_reg      <= '0;
            stored_reg   <= '0;
            end_seen_reg <= 1'b0;
            end_off_reg  <= '0;
            run_reg      <= '0;
            wptr_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            head_reg     <= head_next;
            ptr_reg      <= ptr_next;
            stored_reg   <= stored_next;
            end_seen_reg <= end_seen_next;
            end_off_reg  <= end_off_next;
            run_reg      <= run_next;
            wptr_reg     <= wptr_next;
        end
    end

    // Slot memory: write on store, registered read of the head slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[store_idx] <= in_byte;
        if (state_reg == S_READ)
            rd_data_reg <= slot_mem[ptr_reg];
    end

endmodule
